// File: hdl/mesi_directory_manager_assert.svh
// assertion macros for the mesi directory manager
// no dependencies; taken in by every rtl file that asserts
`ifndef MESI_DIRECTORY_MANAGER_ASSERT_SVH
`define MESI_DIRECTORY_MANAGER_ASSERT_SVH
`ifndef ASSERT_OFF
// concurrent check on an explicit clock and active-low reset
`define MDM_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// concurrent check on the usual clk_i / rst_ni pair
`define MDM_ASSERT(label, prop, msg) \
  `MDM_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)
`else
`define MDM_ASSERT_CLK(label, clk, rst_n, prop, msg)
`define MDM_ASSERT(label, prop, msg)
`endif
`endif

// File: hdl/mdm_pkg.sv
// shared types, codes and helpers of the mesi directory manager
// no dependencies; used by mdm_ctrl, mdm_dp and the top level
package mdm_pkg;

  localparam int NUM_CLIENTS = 16;
  // client ids are four bits wide, so at most sixteen clients are tracked
  localparam int CLIENT_LIM  = (NUM_CLIENTS < 16) ? NUM_CLIENTS : 16;
  localparam int IDX_W       = $clog2(CLIENT_LIM);
  localparam int CLIENT_W    = 4;
  localparam int REQ_W       = 4;
  localparam int CNT_W       = 5;

  typedef logic [CLIENT_W-1:0]   client_t;
  typedef logic [CLIENT_LIM-1:0] cmask_t;
  typedef logic [IDX_W-1:0]      idx_t;
  typedef logic [CNT_W-1:0]      cnt_t;

  localparam logic [CLIENT_W:0] CLIENT_LIM_V = (CLIENT_W + 1)'(CLIENT_LIM);

  typedef enum logic [REQ_W-1:0] {
    RQ_I_TO_E          = 4'd0,
    RQ_I_TO_S          = 4'd1,
    RQ_E_TO_I          = 4'd2,
    RQ_M_TO_I          = 4'd3,
    RQ_UNBLOCK_E       = 4'd4,
    RQ_UNBLOCK_S       = 4'd5,
    RQ_UNBLOCK_I       = 4'd6,
    RQ_UNBLOCK_I_DIRTY = 4'd7,
    RQ_CLEAN           = 4'd8,
    RQ_WRITEBACK       = 4'd9,
    RQ_EVICT           = 4'd10
  } req_e;

  typedef enum logic [2:0] {
    ACT_SEND      = 3'd0,
    ACT_WB        = 3'd1,
    ACT_LOCAL_INV = 3'd2,
    ACT_IGNORE    = 3'd3,
    ACT_INVALID   = 3'd4
  } action_e;

  typedef enum logic [2:0] {
    MSG_GRANT_E  = 3'd0,
    MSG_GRANT_S  = 3'd1,
    MSG_GRANT_I  = 3'd2,
    MSG_FWD_E    = 3'd3,
    MSG_FWD_S    = 3'd4,
    MSG_DEMAND_I = 3'd5
  } msg_e;

  // coherence state of the line, one-hot
  typedef enum logic [10:0] {
    MS_I        = 11'b000_0000_0001,
    MS_E        = 11'b000_0000_0010,
    MS_S        = 11'b000_0000_0100,
    MS_IE       = 11'b000_0000_1000,
    MS_EE       = 11'b000_0001_0000,
    MS_EI_PUT   = 11'b000_0010_0000,
    MS_EI_EVICT = 11'b000_0100_0000,
    MS_ES       = 11'b000_1000_0000,
    MS_SS       = 11'b001_0000_0000,
    MS_SIE      = 11'b010_0000_0000,
    MS_SI_EVICT = 11'b100_0000_0000
  } mgr_state_e;

  // sequencer states, one-hot
  typedef enum logic [4:0] {
    CS_IDLE   = 5'b00001,
    CS_DECODE = 5'b00010,
    CS_EMIT_A = 5'b00100,
    CS_WALK   = 5'b01000,
    CS_EMIT_B = 5'b10000
  } ctrl_state_e;

  typedef struct packed {
    action_e action;
    msg_e    kind;
    logic    is_req;
    client_t dest;
    client_t fwd;
  } ev_t;

  // sequencer to datapath
  typedef struct packed {
    logic capture;
    logic commit;
    logic emit_a;
    logic emit_b;
    logic walk_emit;
    logic walk_skip;
    logic walk_fin;
  } ctrl_cmd_t;

  // datapath to sequencer
  typedef struct packed {
    logic a_valid;
    logic b_valid;
    logic walk;
    logic walk_empty;
    logic walk_bit;
    logic out_free;
  } dp_stat_t;

  function automatic ev_t ev_send(msg_e kind, logic is_req, client_t dest, client_t fwd);
    ev_t e;
    e.action = ACT_SEND;
    e.kind   = kind;
    e.is_req = is_req;
    e.dest   = dest;
    e.fwd    = fwd;
    return e;
  endfunction

  function automatic ev_t ev_simple(action_e act);
    ev_t e;
    e.action = act;
    e.kind   = MSG_GRANT_E;
    e.is_req = 1'b0;
    e.dest   = '0;
    e.fwd    = '0;
    return e;
  endfunction

endpackage

// File: hdl/mdm_ctrl.sv
// sequencer of the mesi directory manager
// depends on mdm_pkg and mesi_directory_manager_assert.svh
`include "mesi_directory_manager_assert.svh"

module mdm_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mdm_pkg::dp_stat_t    stat_i,
  output mdm_pkg::ctrl_cmd_t   cmd_o
);

  mdm_pkg::ctrl_state_e state_q, state_d;

  always_comb begin
    cmd_o      = '0;
    state_d    = state_q;
    in_stall_o = (state_q != mdm_pkg::CS_IDLE);
    unique case (state_q)
      mdm_pkg::CS_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = mdm_pkg::CS_DECODE;
        end
      end
      mdm_pkg::CS_DECODE: begin
        cmd_o.commit = 1'b1;
        state_d      = mdm_pkg::CS_EMIT_A;
      end
      mdm_pkg::CS_EMIT_A: begin
        if (stat_i.a_valid) begin
          if (stat_i.out_free) begin
            cmd_o.emit_a = 1'b1;
            state_d      = stat_i.b_valid ? mdm_pkg::CS_EMIT_B : mdm_pkg::CS_IDLE;
          end
        end else if (stat_i.walk) begin
          state_d = mdm_pkg::CS_WALK;
        end else begin
          state_d = mdm_pkg::CS_IDLE;
        end
      end
      mdm_pkg::CS_WALK: begin
        if (stat_i.walk_empty) begin
          cmd_o.walk_fin = 1'b1;
          state_d        = mdm_pkg::CS_EMIT_B;
        end else if (stat_i.walk_bit) begin
          if (stat_i.out_free) begin
            cmd_o.walk_emit = 1'b1;
          end
        end else begin
          cmd_o.walk_skip = 1'b1;
        end
      end
      mdm_pkg::CS_EMIT_B: begin
        if (!stat_i.b_valid) begin
          state_d = mdm_pkg::CS_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit_b = 1'b1;
          state_d      = mdm_pkg::CS_IDLE;
        end
      end
      default: begin
        state_d = mdm_pkg::CS_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mdm_pkg::CS_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // a result is only pushed when the output register can take it
  `MDM_ASSERT(a_emit_needs_room, (cmd_o.emit_a || cmd_o.emit_b || cmd_o.walk_emit) |-> stat_i.out_free, "result pushed into a full output register")

endmodule

// File: hdl/mdm_dp.sv
// datapath of the mesi directory manager: line state, message decode,
// sharer walk and output register; depends on mdm_pkg and the assert header
`include "mesi_directory_manager_assert.svh"

module mdm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [mdm_pkg::REQ_W-1:0]     req_type_i,
  input  logic [mdm_pkg::CLIENT_W-1:0]  src_client_i,
  input  mdm_pkg::ctrl_cmd_t            cmd_i,
  output mdm_pkg::dp_stat_t             stat_o,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output logic [2:0]                    action_o,
  output logic [2:0]                    msg_kind_o,
  output logic                          is_request_o,
  output logic [mdm_pkg::CLIENT_W-1:0]  dest_client_o,
  output logic [mdm_pkg::CLIENT_W-1:0]  forward_to_o,
  output logic                          busy_res_o,
  output logic                          last_o
);

  // captured item
  logic [mdm_pkg::REQ_W-1:0] req_q;
  mdm_pkg::client_t          src_q;

  // line state
  mdm_pkg::mgr_state_e st_q, st_d;
  mdm_pkg::client_t    owner_q, owner_d;
  logic                ov_q, ov_d;
  mdm_pkg::cmask_t     mask_q, mask_d;
  mdm_pkg::cnt_t       cnt_q, cnt_d;
  mdm_pkg::cnt_t       need_q, need_d;
  logic                us_q, us_d;
  logic                cs_q, cs_d;

  // result plan of the current item
  mdm_pkg::ev_t    a_q, b_q;
  logic            a_v_q, b_v_q, walk_q;
  mdm_pkg::cmask_t wmask_q;
  mdm_pkg::idx_t   widx_q;

  // decode outputs
  logic                dec_bad;
  mdm_pkg::mgr_state_e dec_st;
  mdm_pkg::client_t    dec_owner;
  logic                dec_ov;
  mdm_pkg::cmask_t     dec_mask;
  mdm_pkg::cnt_t       dec_cnt;
  mdm_pkg::cnt_t       dec_need;
  logic                dec_us, dec_cs;
  logic                dec_a_v, dec_b_v, dec_walk;
  mdm_pkg::ev_t        dec_a, dec_b;
  mdm_pkg::cmask_t     dec_wmask;
  mdm_pkg::cmask_t     src_bit, own_bit, widx_bit;
  mdm_pkg::cnt_t       cnt_inc;

  // output register
  logic         out_valid_q;
  mdm_pkg::ev_t out_ev_q;
  logic         out_busy_q, out_last_q;
  logic         out_free;
  logic         busy_now;

  assign src_bit  = mdm_pkg::cmask_t'(1) << src_q[mdm_pkg::IDX_W-1:0];
  assign own_bit  = mdm_pkg::cmask_t'(1) << owner_q[mdm_pkg::IDX_W-1:0];
  assign widx_bit = mdm_pkg::cmask_t'(1) << widx_q;
  assign cnt_inc  = cnt_q + mdm_pkg::cnt_t'(1);
  assign busy_now = !(st_q == mdm_pkg::MS_I || st_q == mdm_pkg::MS_E || st_q == mdm_pkg::MS_S);
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin : decode
    dec_bad   = 1'b0;
    dec_st    = st_q;
    dec_owner = owner_q;
    dec_ov    = ov_q;
    dec_mask  = mask_q;
    dec_cnt   = cnt_q;
    dec_need  = need_q;
    dec_us    = us_q;
    dec_cs    = cs_q;
    dec_a_v   = 1'b0;
    dec_b_v   = 1'b0;
    dec_walk  = 1'b0;
    dec_a     = mdm_pkg::ev_simple(mdm_pkg::ACT_SEND);
    dec_b     = mdm_pkg::ev_simple(mdm_pkg::ACT_SEND);
    dec_wmask = '0;
    if (req_q > mdm_pkg::RQ_EVICT ||
        (req_q != mdm_pkg::RQ_EVICT && {1'b0, src_q} >= mdm_pkg::CLIENT_LIM_V)) begin
      dec_bad = 1'b1;
    end else begin
      unique case (st_q)
        mdm_pkg::MS_I: begin
          if (req_q == mdm_pkg::RQ_I_TO_E || req_q == mdm_pkg::RQ_I_TO_S) begin
            dec_a_v   = 1'b1;
            dec_a     = mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_E, 1'b0, src_q, '0);
            dec_owner = src_q;
            dec_ov    = 1'b1;
            dec_st    = mdm_pkg::MS_IE;
          end else if (req_q == mdm_pkg::RQ_E_TO_I || req_q == mdm_pkg::RQ_M_TO_I) begin
            dec_a_v = 1'b1;
            dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_IGNORE);
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_E: begin
          if (req_q == mdm_pkg::RQ_I_TO_E) begin
            // owner asking again for exclusive is a protocol error
            if (ov_q && owner_q == src_q) begin
              dec_bad = 1'b1;
            end else begin
              dec_a_v   = 1'b1;
              dec_a     = mdm_pkg::ev_send(mdm_pkg::MSG_FWD_E, 1'b1, owner_q, src_q);
              dec_owner = src_q;
              dec_ov    = 1'b1;
              dec_st    = mdm_pkg::MS_EE;
            end
          end else if (req_q == mdm_pkg::RQ_I_TO_S) begin
            dec_a_v   = 1'b1;
            dec_a     = mdm_pkg::ev_send(mdm_pkg::MSG_FWD_S, 1'b1, owner_q, src_q);
            dec_mask  = mask_q | own_bit | src_bit;
            dec_owner = '0;
            dec_ov    = 1'b0;
            dec_st    = mdm_pkg::MS_ES;
          end else if (req_q == mdm_pkg::RQ_EVICT) begin
            dec_a_v   = 1'b1;
            dec_a     = mdm_pkg::ev_send(mdm_pkg::MSG_DEMAND_I, 1'b1, owner_q, '0);
            dec_owner = '0;
            dec_ov    = 1'b0;
            dec_st    = mdm_pkg::MS_EI_EVICT;
          end else if (req_q == mdm_pkg::RQ_E_TO_I || req_q == mdm_pkg::RQ_M_TO_I) begin
            dec_a_v = 1'b1;
            if (ov_q && src_q == owner_q) begin
              if (req_q == mdm_pkg::RQ_M_TO_I) begin
                dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_WB);
                dec_b_v = 1'b1;
                dec_b   = mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_I, 1'b0, owner_q, '0);
              end else begin
                dec_a   = mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_I, 1'b0, owner_q, '0);
              end
              dec_owner = '0;
              dec_ov    = 1'b0;
              dec_st    = mdm_pkg::MS_EI_PUT;
            end else begin
              dec_a = mdm_pkg::ev_simple(mdm_pkg::ACT_IGNORE);
            end
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_S: begin
          if (req_q == mdm_pkg::RQ_I_TO_S) begin
            dec_a_v  = 1'b1;
            dec_a    = mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_S, 1'b0, src_q, '0);
            dec_mask = mask_q | src_bit;
            dec_st   = mdm_pkg::MS_SS;
          end else if (req_q == mdm_pkg::RQ_I_TO_E || req_q == mdm_pkg::RQ_EVICT) begin
            // sharers get demand-invalidates in the walk; count is settled there
            dec_walk = 1'b1;
            dec_mask = '0;
            dec_cnt  = '0;
            dec_need = '0;
            if (req_q == mdm_pkg::RQ_I_TO_E) begin
              dec_wmask = mask_q & ~src_bit;
              dec_owner = src_q;
              dec_ov    = 1'b1;
              dec_st    = mdm_pkg::MS_SIE;
            end else begin
              dec_wmask = mask_q;
              dec_st    = mdm_pkg::MS_SI_EVICT;
            end
          end else if (req_q == mdm_pkg::RQ_E_TO_I || req_q == mdm_pkg::RQ_M_TO_I) begin
            dec_a_v = 1'b1;
            dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_IGNORE);
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_IE, mdm_pkg::MS_EE: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_E) begin
            dec_st = mdm_pkg::MS_E;
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_EI_PUT: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_I) begin
            dec_a_v = 1'b1;
            dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_LOCAL_INV);
            dec_st  = mdm_pkg::MS_I;
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_EI_EVICT: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_I) begin
            dec_a_v = 1'b1;
            dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_LOCAL_INV);
            dec_st  = mdm_pkg::MS_I;
          end else if (req_q == mdm_pkg::RQ_UNBLOCK_I_DIRTY) begin
            dec_a_v = 1'b1;
            dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_WB);
            dec_b_v = 1'b1;
            dec_b   = mdm_pkg::ev_simple(mdm_pkg::ACT_LOCAL_INV);
            dec_st  = mdm_pkg::MS_I;
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_ES: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_E) begin
            dec_mask  = '0;
            dec_owner = src_q;
            dec_ov    = 1'b1;
            dec_us    = 1'b0;
            dec_cs    = 1'b0;
            dec_st    = mdm_pkg::MS_E;
          end else if (req_q == mdm_pkg::RQ_UNBLOCK_S) begin
            if (us_q) begin
              dec_bad = 1'b1;
            end else begin
              dec_us = 1'b1;
            end
          end else if (req_q == mdm_pkg::RQ_CLEAN || req_q == mdm_pkg::RQ_WRITEBACK) begin
            if (cs_q) begin
              dec_bad = 1'b1;
            end else begin
              dec_cs = 1'b1;
              if (req_q == mdm_pkg::RQ_WRITEBACK) begin
                dec_a_v = 1'b1;
                dec_a   = mdm_pkg::ev_simple(mdm_pkg::ACT_WB);
              end
            end
          end else begin
            dec_bad = 1'b1;
          end
          // both halves of the handoff seen: settle in shared
          if (!dec_bad && dec_st == mdm_pkg::MS_ES && dec_us && dec_cs) begin
            dec_us = 1'b0;
            dec_cs = 1'b0;
            dec_st = mdm_pkg::MS_S;
          end
        end
        mdm_pkg::MS_SS: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_S) begin
            dec_st = mdm_pkg::MS_S;
          end else begin
            dec_bad = 1'b1;
          end
        end
        mdm_pkg::MS_SIE, mdm_pkg::MS_SI_EVICT: begin
          if (req_q == mdm_pkg::RQ_UNBLOCK_I) begin
            dec_cnt = cnt_inc;
            if (cnt_inc == need_q) begin
              dec_a_v = 1'b1;
              if (st_q == mdm_pkg::MS_SI_EVICT) begin
                dec_a  = mdm_pkg::ev_simple(mdm_pkg::ACT_LOCAL_INV);
                dec_st = mdm_pkg::MS_I;
              end else begin
                dec_a  = mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_E, 1'b0, owner_q, '0);
                dec_st = mdm_pkg::MS_IE;
              end
            end
          end else begin
            dec_bad = 1'b1;
          end
        end
        default: begin
          dec_bad = 1'b1;
        end
      endcase
    end
    // an invalid message touches no state and gives a single error result
    if (dec_bad) begin
      dec_st    = st_q;
      dec_owner = owner_q;
      dec_ov    = ov_q;
      dec_mask  = mask_q;
      dec_cnt   = cnt_q;
      dec_need  = need_q;
      dec_us    = us_q;
      dec_cs    = cs_q;
      dec_walk  = 1'b0;
      dec_wmask = '0;
      dec_b_v   = 1'b0;
      dec_a_v   = 1'b1;
      dec_a     = mdm_pkg::ev_simple(mdm_pkg::ACT_INVALID);
    end
  end

  always_comb begin : next_state
    st_d    = st_q;
    owner_d = owner_q;
    ov_d    = ov_q;
    mask_d  = mask_q;
    cnt_d   = cnt_q;
    need_d  = need_q;
    us_d    = us_q;
    cs_d    = cs_q;
    if (cmd_i.commit) begin
      st_d    = dec_st;
      owner_d = dec_owner;
      ov_d    = dec_ov;
      mask_d  = dec_mask;
      cnt_d   = dec_cnt;
      need_d  = dec_need;
      us_d    = dec_us;
      cs_d    = dec_cs;
    end
    if (cmd_i.walk_emit) begin
      need_d = need_q + mdm_pkg::cnt_t'(1);
    end
    // nobody to invalidate: finish at once
    if (cmd_i.walk_fin && need_q == '0) begin
      st_d = (st_q == mdm_pkg::MS_SIE) ? mdm_pkg::MS_IE : mdm_pkg::MS_I;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= mdm_pkg::MS_I;
      owner_q <= '0;
      ov_q    <= 1'b0;
      mask_q  <= '0;
      cnt_q   <= '0;
      need_q  <= '0;
      us_q    <= 1'b0;
      cs_q    <= 1'b0;
    end else begin
      st_q    <= st_d;
      owner_q <= owner_d;
      ov_q    <= ov_d;
      mask_q  <= mask_d;
      cnt_q   <= cnt_d;
      need_q  <= need_d;
      us_q    <= us_d;
      cs_q    <= cs_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_type_i;
      src_q <= src_client_i;
    end
    if (cmd_i.commit) begin
      a_q <= dec_a;
      b_q <= dec_b;
    end else if (cmd_i.walk_fin) begin
      b_q <= (st_q == mdm_pkg::MS_SIE) ?
             mdm_pkg::ev_send(mdm_pkg::MSG_GRANT_E, 1'b0, owner_q, '0) :
             mdm_pkg::ev_simple(mdm_pkg::ACT_LOCAL_INV);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q   <= 1'b0;
      b_v_q   <= 1'b0;
      walk_q  <= 1'b0;
      wmask_q <= '0;
      widx_q  <= '0;
    end else begin
      if (cmd_i.commit) begin
        a_v_q   <= dec_a_v;
        b_v_q   <= dec_b_v;
        walk_q  <= dec_walk;
        wmask_q <= dec_wmask;
        widx_q  <= '0;
      end else if (cmd_i.walk_emit) begin
        wmask_q <= wmask_q & ~widx_bit;
        widx_q  <= widx_q + mdm_pkg::idx_t'(1);
      end else if (cmd_i.walk_skip) begin
        widx_q  <= widx_q + mdm_pkg::idx_t'(1);
      end else if (cmd_i.walk_fin) begin
        b_v_q   <= (need_q == '0);
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_a || cmd_i.emit_b || cmd_i.walk_emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_a) begin
      out_ev_q   <= a_q;
      out_busy_q <= busy_now;
      out_last_q <= !b_v_q;
    end else if (cmd_i.emit_b) begin
      out_ev_q   <= b_q;
      out_busy_q <= busy_now;
      out_last_q <= 1'b1;
    end else if (cmd_i.walk_emit) begin
      out_ev_q   <= mdm_pkg::ev_send(mdm_pkg::MSG_DEMAND_I, 1'b1,
                                     mdm_pkg::client_t'(widx_q), '0);
      out_busy_q <= busy_now;
      out_last_q <= ((wmask_q & ~widx_bit) == '0);
    end
  end

  assign stat_o.a_valid    = a_v_q;
  assign stat_o.b_valid    = b_v_q;
  assign stat_o.walk       = walk_q;
  assign stat_o.walk_empty = (wmask_q == '0);
  assign stat_o.walk_bit   = wmask_q[widx_q];
  assign stat_o.out_free   = out_free;

  assign out_valid_o   = out_valid_q;
  assign action_o      = out_ev_q.action;
  assign msg_kind_o    = out_ev_q.kind;
  assign is_request_o  = out_ev_q.is_req;
  assign dest_client_o = out_ev_q.dest;
  assign forward_to_o  = out_ev_q.fwd;
  assign busy_res_o    = out_busy_q;
  assign last_o        = out_last_q;

  `MDM_ASSERT(a_walk_on_sharer, cmd_i.walk_emit |-> wmask_q[widx_q], "demand-invalidate sent to a non-sharer")
  `MDM_ASSERT(a_need_bounded, need_q <= mdm_pkg::cnt_t'(mdm_pkg::CLIENT_LIM), "invalidation count beyond client count")
  `MDM_ASSERT(a_e_has_owner, (st_q == mdm_pkg::MS_E) |-> ov_q, "exclusive state without an owner")
  `MDM_ASSERT(a_no_stale_sharers, (st_q == mdm_pkg::MS_I || st_q == mdm_pkg::MS_E) |-> (mask_q == '0), "sharers left in invalid or exclusive state")

endmodule

// File: hdl/mesi_directory_manager.sv
// top level of the mesi directory manager
// depends on mdm_pkg, mdm_ctrl and mdm_dp
//
// directory-side mesi manager for one cache line. each input item is a
// coherence message from a client (or a local evict demand) and yields zero
// to sixteen result items, the final one flagged by last_o; an invalid
// message yields a single error item and leaves the line untouched. one item
// is handled at a time: in_stall_o drops only when the sequencer is idle, and
// the next item is taken while the previous result still sits in the single
// output register. a shared-line upgrade or evict walks the sharer mask one
// client per cycle while the output is not stalled.
module mesi_directory_manager (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // item input
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [mdm_pkg::REQ_W-1:0]     req_type_i,
  input  logic [mdm_pkg::CLIENT_W-1:0]  src_client_i,
  // result output
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [2:0]                    action_o,
  output logic [2:0]                    msg_kind_o,
  output logic                          is_request_o,
  output logic [mdm_pkg::CLIENT_W-1:0]  dest_client_o,
  output logic [mdm_pkg::CLIENT_W-1:0]  forward_to_o,
  output logic                          busy_res_o,
  output logic                          last_o
);

  // command and status between sequencer and datapath
  mdm_pkg::ctrl_cmd_t cmd;
  mdm_pkg::dp_stat_t  stat;

  // sequencer: capture, decode, first result, sharer walk, closing result
  mdm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // line state, message decode, walk registers and output register
  mdm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_type_i    (req_type_i),
    .src_client_i  (src_client_i),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .action_o      (action_o),
    .msg_kind_o    (msg_kind_o),
    .is_request_o  (is_request_o),
    .dest_client_o (dest_client_o),
    .forward_to_o  (forward_to_o),
    .busy_res_o    (busy_res_o),
    .last_o        (last_o)
  );

endmodule
